/* hdl/kbp_pkg.sv */
package kbp_pkg;

	localparam int MAX_FRAMES = 64;
	localparam int FRAME_AW = $clog2(MAX_FRAMES);
	localparam int DIV_W = 34;
	localparam int COEF_W = 40;
	localparam int ACC_W = 42;

	localparam logic [DIV_W-1:0] SEG_LEN = 34'd65536000;
	localparam logic [31:0] SPEED_RESET = 32'd1638400;

	// segment = (t >> 16) / 1000, lambda = rem / 1000, both by reciprocal multiply
	localparam logic [9:0] MS_DIV = 10'd1000;
	localparam logic [16:0] SEG_RECIP = 17'd67109;
	localparam int SEG_SHIFT = 26;
	localparam logic [26:0] MS_RECIP = 27'd68719477;
	localparam int MS_SHIFT = 36;

	localparam logic [1:0] REG_FRAME_COUNT = 2'd0;
	localparam logic [1:0] REG_LOOP_ENABLE = 2'd1;
	localparam logic [1:0] REG_TARGET_SPEED = 2'd2;

	localparam logic [2:0] CMD_TICK = 3'd0;
	localparam logic [2:0] CMD_WRITE = 3'd1;
	localparam logic [2:0] CMD_JUMP = 3'd2;
	localparam logic [2:0] CMD_PAUSE = 3'd3;
	localparam logic [2:0] CMD_START = 3'd4;

	typedef enum logic [2:0] {
		OP_TICK,
		OP_WRITE,
		OP_JUMP,
		OP_PAUSE,
		OP_RESUME,
		OP_NONE
	} op_t;

	typedef struct packed {
		op_t op;
		logic [5:0] frame_index;
		logic [31:0] key_x;
		logic [31:0] key_y;
		logic [31:0] key_z;
		logic [31:0] time_value;
	} item_t;

	typedef struct packed {
		logic valid;
		item_t item;
	} qhead_t;

	typedef struct packed {
		logic [6:0] frame_count;
		logic loop_enable;
		logic [31:0] target_speed;
	} cfg_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_EXEC,
		ST_WRAP,
		ST_SEG,
		ST_REM,
		ST_LAM,
		ST_LAM2,
		ST_LAM3,
		ST_READ,
		ST_COEF,
		ST_MUL,
		ST_FIN,
		ST_SQ,
		ST_SQA,
		ST_SQRT,
		ST_STEP,
		ST_DIVGO,
		ST_DIV,
		ST_EMIT
	} back_state_t;

	// v * f / 2^16, truncated toward zero
	function automatic logic signed [COEF_W-1:0] mulq(input logic signed [COEF_W-1:0] v,
			input logic [15:0] f);
		logic [COEF_W-1:0] mag;
		logic [COEF_W+15:0] p;
		logic [COEF_W-1:0] r;
		mag = v[COEF_W-1] ? COEF_W'(-v) : COEF_W'(v);
		p = mag * f;
		r = p[COEF_W+15:16];
		return v[COEF_W-1] ? $signed(-r) : $signed(r);
	endfunction

	function automatic logic signed [COEF_W-1:0] div4(input logic signed [COEF_W-1:0] x);
		return x[COEF_W-1] ? ((x + COEF_W'(3)) >>> 2) : (x >>> 2);
	endfunction

	function automatic logic [31:0] sat32(input logic signed [ACC_W-1:0] v);
		logic [ACC_W-32:0] top;
		top = v[ACC_W-1:31];
		if (top == '0 || top == '1) begin
			return v[31:0];
		end else if (v[ACC_W-1]) begin
			return 32'h8000_0000;
		end else begin
			return 32'h7fff_ffff;
		end
	endfunction

endpackage

/* hdl/keyframe_bezier_path_player.sv */
// write, jump, pause, start and held ticks go from the execute state straight to emit
// a moving tick runs the 32-step wrap divide if time wraps, then segment, lambda, Bezier terms,
// the 32-step square root and, unless the derivative is zero, the 64-step time-advance divide
// the back end takes one item at a time, a 2-entry queue takes items ahead
// result_valid is high for one cycle per item and the receiver cannot stall
// reset clears path time, held position, pause flag, queue and registers; keyframes are not cleared
module keyframe_bezier_path_player (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [3:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input logic start,
	input logic [2:0] command,
	input logic [5:0] frame_index,
	input logic signed [31:0] key_x,
	input logic signed [31:0] key_y,
	input logic signed [31:0] key_z,
	input logic [31:0] time_value,
	output logic busy,
	output logic result_valid,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z,
	output logic [31:0] out_time,
	output logic moved,
	output logic speed_fault
);
	import kbp_pkg::*;

	cfg_t cfg_q;
	qhead_t head;
	logic pop;
	logic wr_en;
	logic [31:0] bx, by, bz;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_count <= 7'd0;
			cfg_q.loop_enable <= 1'b0;
			cfg_q.target_speed <= SPEED_RESET;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_FRAME_COUNT: cfg_q.frame_count <= pwdata[6:0];
				REG_LOOP_ENABLE: cfg_q.loop_enable <= pwdata[0];
				REG_TARGET_SPEED: cfg_q.target_speed <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_FRAME_COUNT: prdata = 32'(cfg_q.frame_count);
			REG_LOOP_ENABLE: prdata = 32'(cfg_q.loop_enable);
			REG_TARGET_SPEED: prdata = cfg_q.target_speed;
			default: prdata = 32'd0;
		endcase
	end

	kbp_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.command(command),
		.frame_index(frame_index),
		.key_x(key_x),
		.key_y(key_y),
		.key_z(key_z),
		.time_value(time_value),
		.busy(busy),
		.head(head),
		.pop(pop)
	);

	kbp_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.head(head),
		.pop(pop),
		.out_x(bx),
		.out_y(by),
		.out_z(bz),
		.out_time(out_time),
		.moved(moved),
		.speed_fault(speed_fault),
		.result_valid(result_valid)
	);

	assign out_x = $signed(bx);
	assign out_y = $signed(by);
	assign out_z = $signed(bz);

endmodule

/* hdl/kbp_front.sv */
module kbp_front (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [2:0] command,
	input logic [5:0] frame_index,
	input logic [31:0] key_x,
	input logic [31:0] key_y,
	input logic [31:0] key_z,
	input logic [31:0] time_value,
	output logic busy,
	output kbp_pkg::qhead_t head,
	input logic pop
);
	import kbp_pkg::*;

	item_t que_q [0:1];
	item_t in_item;
	logic wr_q;
	logic rd_q;
	logic [1:0] cnt_q;
	logic push;
	op_t op;

	always_comb begin
		unique case (command)
			CMD_TICK: op = OP_TICK;
			CMD_WRITE: op = OP_WRITE;
			CMD_JUMP: op = OP_JUMP;
			CMD_PAUSE: op = OP_PAUSE;
			CMD_START: op = OP_RESUME;
			default: op = OP_NONE;
		endcase
	end

	always_comb begin
		in_item.op = op;
		in_item.frame_index = frame_index;
		in_item.key_x = key_x;
		in_item.key_y = key_y;
		in_item.key_z = key_z;
		in_item.time_value = time_value;
	end

	assign busy = (cnt_q == 2'd2);
	assign push = start && !busy;
	assign head.valid = (cnt_q != 2'd0);
	assign head.item = que_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop && head.valid) begin
				rd_q <= !rd_q;
			end
			priority if (push && !(pop && head.valid)) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!push && pop && head.valid) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			que_q[wr_q] <= in_item;
		end
	end

endmodule

/* hdl/kbp_divu.sv */
module kbp_divu (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic short_mode,
	input logic [63:0] dividend,
	input logic [kbp_pkg::DIV_W-1:0] divisor,
	output logic done,
	output logic [63:0] quotient,
	output logic [kbp_pkg::DIV_W-1:0] remainder
);
	import kbp_pkg::*;

	logic [63:0] q_q;
	logic [DIV_W-1:0] r_q;
	logic [DIV_W-1:0] d_q;
	logic [6:0] cnt_q;
	logic run_q;
	logic done_q;
	logic [DIV_W:0] rs;
	logic [DIV_W:0] rn;
	logic ge;

	always_comb begin
		rs = {r_q, q_q[63]};
		ge = (rs >= {1'b0, d_q});
		rn = ge ? (rs - {1'b0, d_q}) : rs;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= 7'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= short_mode ? 7'd32 : 7'd64;
			end else if (run_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= short_mode ? {dividend[31:0], 32'd0} : dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (run_q) begin
			q_q <= {q_q[62:0], ge};
			r_q <= rn[DIV_W-1:0];
		end
	end

	assign done = done_q;
	assign quotient = q_q;
	assign remainder = r_q;

endmodule

/* hdl/kbp_isqrt.sv */
module kbp_isqrt (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [63:0] value,
	output logic done,
	output logic [31:0] root
);

	logic [63:0] v_q;
	logic [63:0] res_q;
	logic [63:0] bit_q;
	logic [5:0] cnt_q;
	logic run_q;
	logic done_q;
	logic [63:0] trial;

	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= 6'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 6'd32;
			end else if (run_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q <= value;
			res_q <= '0;
			bit_q <= 64'h4000_0000_0000_0000;
		end else if (run_q) begin
			if (v_q >= trial) begin
				v_q <= v_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[31:0];

endmodule

/* hdl/kbp_back.sv */
module kbp_back (
	input logic clk,
	input logic arst_n,
	input kbp_pkg::cfg_t cfg,
	input kbp_pkg::qhead_t head,
	output logic pop,
	output logic [31:0] out_x,
	output logic [31:0] out_y,
	output logic [31:0] out_z,
	output logic [31:0] out_time,
	output logic moved,
	output logic speed_fault,
	output logic result_valid
);
	import kbp_pkg::*;

	back_state_t state_q, state_d;
	item_t cur_q;
	logic paused_q;
	logic [31:0] time_q;
	logic [31:0] t_q;
	logic [31:0] held_q [0:2];
	logic moved_q;
	logic fault_q;
	logic [6:0] k_q;
	logic [25:0] rem_q;
	logic [15:0] lam_q;
	logic [15:0] lam2_q;
	logic [15:0] lam3_q;
	logic [95:0] mem [0:MAX_FRAMES-1];
	logic [95:0] rd_q;
	logic [95:0] pts_q [0:3];
	logic [1:0] ax_q;
	logic [2:0] cnt_q;
	logic signed [COEF_W-1:0] c1_q, c2_q, c3_q, d2_q, d3_q;
	logic signed [COEF_W-1:0] prod_q;
	logic signed [ACC_W-1:0] pos_acc_q, der_acc_q;
	logic [31:0] der_q;
	logic [63:0] sqp_q;
	logic [63:0] sq_q;
	logic [31:0] len_q;
	logic [63:0] stp_q;

	logic div_start, div_short, div_done;
	logic [63:0] div_a, div_q;
	logic [DIV_W-1:0] div_b, div_r;
	logic sq_start, sq_done;
	logic [31:0] sq_root;

	logic [6:0] n7, kp7, kn7, knn7, rsel7;
	logic [FRAME_AW-1:0] rd_addr, wr_addr;
	logic [DIV_W-1:0] end_len;
	logic frames_ok, past_end, wr_ok;
	logic signed [COEF_W-1:0] sp, sa, sd, sn, bb, cc;
	logic signed [COEF_W-1:0] c1_d, c2_d, c3_d;
	logic signed [COEF_W-1:0] m_op;
	logic [15:0] m_fac;
	logic signed [31:0] der_s;
	logic signed [63:0] der_sq;
	logic [63:0] stp_d;
	logic [32:0] sum33;
	logic [31:0] nt;
	logic [6:0] k_inc, kn_inc;
	logic [32:0] seg_prod;
	logic [6:0] k_d;
	logic [15:0] rhi_d;
	logic [25:0] rem_d;
	logic [52:0] lam_prod;
	logic [15:0] lam_d;

	kbp_divu u_divu (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.short_mode(div_short),
		.dividend(div_a),
		.divisor(div_b),
		.done(div_done),
		.quotient(div_q),
		.remainder(div_r)
	);

	kbp_isqrt u_isqrt (
		.clk(clk),
		.arst_n(arst_n),
		.start(sq_start),
		.value(sq_q + sqp_q),
		.done(sq_done),
		.root(sq_root)
	);

	always_comb begin
		n7 = cfg.frame_count;
		k_inc = k_q + 7'd1;
		kp7 = (k_q == 7'd0) ? (n7 - 7'd1) : (k_q - 7'd1);
		kn7 = (k_inc < n7) ? k_inc : 7'd0;
		kn_inc = kn7 + 7'd1;
		knn7 = (kn_inc < n7) ? kn_inc : 7'd0;
		unique case (cnt_q[1:0])
			2'd0: rsel7 = kp7;
			2'd1: rsel7 = k_q;
			2'd2: rsel7 = kn7;
			default: rsel7 = knn7;
		endcase
		rd_addr = FRAME_AW'(rsel7);
		wr_addr = FRAME_AW'(cur_q.frame_index);
		wr_ok = (int'(cur_q.frame_index) < MAX_FRAMES);
		end_len = DIV_W'(n7) * SEG_LEN;
		frames_ok = (n7 != 7'd0) && (int'(n7) <= MAX_FRAMES);
		past_end = ({2'b00, time_q} >= end_len);
	end

	// segment index, remainder and lambda
	always_comb begin
		seg_prod = 33'(t_q[31:16]) * 33'(SEG_RECIP);
		k_d = 7'(seg_prod >> SEG_SHIFT);
		rhi_d = t_q[31:16] - 16'(k_q) * 16'(MS_DIV);
		rem_d = {rhi_d[9:0], t_q[15:0]};
		lam_prod = 53'(rem_q) * 53'(MS_RECIP);
		lam_d = 16'(lam_prod >> MS_SHIFT);
	end

	always_comb begin
		sp = COEF_W'($signed(pts_q[0][{ax_q, 5'd0} +: 32]));
		sa = COEF_W'($signed(pts_q[1][{ax_q, 5'd0} +: 32]));
		sd = COEF_W'($signed(pts_q[2][{ax_q, 5'd0} +: 32]));
		sn = COEF_W'($signed(pts_q[3][{ax_q, 5'd0} +: 32]));
		bb = sa + div4(sd - sp);
		cc = sd - div4(sn - sa);
		c1_d = COEF_W'(3) * (bb - sa);
		c2_d = COEF_W'(3) * (sa - (bb <<< 1) + cc);
		c3_d = (sd - sa) + COEF_W'(3) * (bb - cc);
	end

	always_comb begin
		unique case (cnt_q)
			3'd0: begin
				m_op = c1_q;
				m_fac = lam_q;
			end
			3'd1: begin
				m_op = c2_q;
				m_fac = lam2_q;
			end
			3'd2: begin
				m_op = c3_q;
				m_fac = lam3_q;
			end
			3'd3: begin
				m_op = d2_q;
				m_fac = lam_q;
			end
			3'd4: begin
				m_op = d3_q;
				m_fac = lam2_q;
			end
			default: begin
				m_op = '0;
				m_fac = '0;
			end
		endcase
	end

	always_comb begin
		der_s = $signed(der_q);
		der_sq = der_s * der_s;
		stp_d = cfg.target_speed * cur_q.time_value;
		sum33 = {1'b0, t_q} + {1'b0, div_q[31:0]};
		if (div_q[63:32] != 32'd0 || sum33[32]) begin
			nt = 32'hffff_ffff;
		end else begin
			nt = sum33[31:0];
		end
	end

	always_comb begin
		state_d = state_q;
		pop = 1'b0;
		div_start = 1'b0;
		div_short = 1'b1;
		div_a = 64'(time_q);
		div_b = SEG_LEN;
		sq_start = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (head.valid) begin
					pop = 1'b1;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_EMIT;
				if (cur_q.op == OP_TICK && !paused_q && frames_ok) begin
					if (!past_end) begin
						state_d = ST_SEG;
					end else if (cfg.loop_enable) begin
						div_start = 1'b1;
						div_b = end_len;
						state_d = ST_WRAP;
					end
				end
			end
			ST_WRAP: begin
				if (div_done) begin
					state_d = ST_SEG;
				end
			end
			ST_SEG: state_d = ST_REM;
			ST_REM: state_d = ST_LAM;
			ST_LAM: state_d = ST_LAM2;
			ST_LAM2: state_d = ST_LAM3;
			ST_LAM3: state_d = ST_READ;
			ST_READ: begin
				if (cnt_q == 3'd4) begin
					state_d = ST_COEF;
				end
			end
			ST_COEF: state_d = ST_MUL;
			ST_MUL: begin
				if (cnt_q == 3'd5) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: state_d = ST_SQ;
			ST_SQ: state_d = ST_SQA;
			ST_SQA: begin
				if (ax_q == 2'd2) begin
					sq_start = 1'b1;
					state_d = ST_SQRT;
				end else begin
					state_d = ST_COEF;
				end
			end
			ST_SQRT: begin
				if (sq_done) begin
					state_d = (sq_root == 32'd0) ? ST_EMIT : ST_STEP;
				end
			end
			ST_STEP: state_d = ST_DIVGO;
			ST_DIVGO: begin
				div_start = 1'b1;
				div_short = 1'b0;
				div_a = stp_q;
				div_b = DIV_W'(len_q);
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			paused_q <= 1'b0;
			time_q <= 32'd0;
			held_q[0] <= 32'd0;
			held_q[1] <= 32'd0;
			held_q[2] <= 32'd0;
			moved_q <= 1'b0;
			fault_q <= 1'b0;
			cnt_q <= 3'd0;
			ax_q <= 2'd0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (head.valid) begin
						moved_q <= 1'b0;
						fault_q <= 1'b0;
					end
				end
				ST_EXEC: begin
					unique case (cur_q.op)
						OP_JUMP: time_q <= cur_q.time_value;
						OP_PAUSE: paused_q <= 1'b1;
						OP_RESUME: paused_q <= 1'b0;
						default: ;
					endcase
				end
				ST_LAM: begin
					moved_q <= 1'b1;
					cnt_q <= 3'd0;
				end
				ST_READ: begin
					if (cnt_q == 3'd4) begin
						cnt_q <= 3'd0;
						ax_q <= 2'd0;
					end else begin
						cnt_q <= cnt_q + 3'd1;
					end
				end
				ST_COEF: cnt_q <= 3'd0;
				ST_MUL: cnt_q <= cnt_q + 3'd1;
				ST_FIN: held_q[ax_q] <= sat32(pos_acc_q);
				ST_SQA: ax_q <= ax_q + 2'd1;
				ST_SQRT: begin
					if (sq_done && sq_root == 32'd0) begin
						fault_q <= 1'b1;
						time_q <= t_q;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						time_q <= nt;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && head.valid) begin
			cur_q <= head.item;
		end
		if (state_q == ST_EXEC) begin
			t_q <= time_q;
		end
		if (state_q == ST_WRAP && div_done) begin
			t_q <= div_r[31:0];
		end
		if (state_q == ST_SEG) begin
			k_q <= k_d;
		end
		if (state_q == ST_REM) begin
			rem_q <= rem_d;
		end
		if (state_q == ST_LAM) begin
			lam_q <= lam_d;
		end
		if (state_q == ST_LAM2) begin
			lam2_q <= 16'((32'(lam_q) * 32'(lam_q)) >> 16);
		end
		if (state_q == ST_LAM3) begin
			lam3_q <= 16'((32'(lam2_q) * 32'(lam_q)) >> 16);
			sq_q <= '0;
			sqp_q <= '0;
		end
		if (state_q == ST_READ && cnt_q != 3'd0) begin
			pts_q[2'(cnt_q - 3'd1)] <= rd_q;
		end
		if (state_q == ST_COEF) begin
			c1_q <= c1_d;
			c2_q <= c2_d;
			c3_q <= c3_d;
			d2_q <= c2_d <<< 1;
			d3_q <= COEF_W'(3) * c3_d;
			pos_acc_q <= ACC_W'(sa);
			der_acc_q <= ACC_W'(c1_d);
		end
		if (state_q == ST_MUL) begin
			if (cnt_q <= 3'd4) begin
				prod_q <= mulq(m_op, m_fac);
			end
			if (cnt_q != 3'd0) begin
				if (cnt_q <= 3'd3) begin
					pos_acc_q <= pos_acc_q + ACC_W'(prod_q);
				end else begin
					der_acc_q <= der_acc_q + ACC_W'(prod_q);
				end
			end
		end
		if (state_q == ST_FIN) begin
			der_q <= sat32(der_acc_q);
		end
		if (state_q == ST_SQ) begin
			sqp_q <= der_sq;
		end
		if (state_q == ST_SQA) begin
			sq_q <= sq_q + sqp_q;
		end
		if (state_q == ST_SQRT && sq_done) begin
			len_q <= sq_root;
		end
		if (state_q == ST_STEP) begin
			stp_q <= stp_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EXEC && cur_q.op == OP_WRITE && wr_ok) begin
			mem[wr_addr] <= {cur_q.key_z, cur_q.key_y, cur_q.key_x};
		end
		rd_q <= mem[rd_addr];
	end

	assign out_x = held_q[0];
	assign out_y = held_q[1];
	assign out_z = held_q[2];
	assign out_time = time_q;
	assign moved = moved_q;
	assign speed_fault = fault_q;
	assign result_valid = (state_q == ST_EMIT);

endmodule

/* hdl/kbp_checker.sv */
module kbp_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic result_valid,
	input logic moved,
	input logic speed_fault
);

	// one result per item, never two in a row
	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe held two cycles");

	// a fault only comes with an evaluated position
	a_fault_moved: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && speed_fault |-> moved)
		else $error("speed fault without motion");

	// queue fills only on an accepted item
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without an item");

endmodule

bind keyframe_bezier_path_player kbp_checker u_kbp_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.result_valid(result_valid),
	.moved(moved),
	.speed_fault(speed_fault)
);

/* test/keyframe_bezier_path_player_tb.sv */
module keyframe_bezier_path_player_tb;
	import kbp_pkg::*;

	localparam logic [2:0] CMD_ODD_LO = 3'd5;
	localparam logic [2:0] CMD_ODD_HI = 3'd7;
	localparam longint unsigned SEG_MS = 64'd65536000;
	localparam int STALL_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 8;

	typedef struct {
		logic [2:0] cmd;
		logic [5:0] idx;
		logic [31:0] kx, ky, kz, tv;
	} path_item_t;

	typedef struct {
		logic [31:0] x, y, z, t;
		logic mv, flt;
	} path_pos_t;

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic start = 0;
	logic [2:0] command = CMD_TICK;
	logic [5:0] frame_index = '0;
	logic signed [31:0] key_x = '0, key_y = '0, key_z = '0;
	logic [31:0] time_value = '0;
	logic busy, result_valid, moved, speed_fault;
	logic signed [31:0] out_x, out_y, out_z;
	logic [31:0] out_time;

	keyframe_bezier_path_player uut (.*);

	always #5 clk = ~clk;

	// shadow of the player
	logic [31:0] key_tab_x [MAX_FRAMES];
	logic [31:0] key_tab_y [MAX_FRAMES];
	logic [31:0] key_tab_z [MAX_FRAMES];
	logic [31:0] play_time = '0;
	logic [31:0] hold_x = '0, hold_y = '0, hold_z = '0;
	logic paused = 0;
	logic [6:0] n_frames = '0;
	logic looping = 0;
	logic [31:0] speed = SPEED_RESET;

	path_pos_t pos_q [$];
	int mismatches = 0;
	int idle_pct = 0;
	int stall_cnt = 0;

	function automatic longint sat_s32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint qmul(longint v, longint unsigned f);
		longint unsigned m;
		m = v < 0 ? longint'(-v) : longint'(v);
		m = (m * f) >> 16;
		return v < 0 ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint bezier_axis(logic [31:0] pa, logic [31:0] pd, logic [31:0] pp,
			logic [31:0] pn, longint unsigned l1, longint unsigned l2,
			longint unsigned l3, output longint der);
		longint a, d, b, c, c1, c2, c3;
		a = longint'(signed'(pa));
		d = longint'(signed'(pd));
		b = a + (d - longint'(signed'(pp))) / 4;
		c = d - (longint'(signed'(pn)) - a) / 4;
		c1 = 3 * (b - a);
		c2 = 3 * (a - 2 * b + c);
		c3 = (d - a) + 3 * (b - c);
		der = sat_s32(c1 + qmul(2 * c2, l1) + qmul(3 * c3, l2));
		return sat_s32(a + qmul(c1, l1) + qmul(c2, l2) + qmul(c3, l3));
	endfunction

	function automatic path_pos_t advance_path(path_item_t it);
		path_pos_t r;
		longint unsigned t, seg_end, l1, l2, l3, sq, len, stp, nt;
		longint dx, dy, dz;
		int n, k, kp, kn, knn;
		bit go;
		r.mv = 0;
		r.flt = 0;
		case (it.cmd)
			CMD_WRITE: begin
				key_tab_x[it.idx] = it.kx;
				key_tab_y[it.idx] = it.ky;
				key_tab_z[it.idx] = it.kz;
			end
			CMD_JUMP: play_time = it.tv;
			CMD_PAUSE: paused = 1;
			CMD_START: paused = 0;
			CMD_TICK: if (!paused && n_frames != 0 && n_frames <= MAX_FRAMES) begin
				n = int'(n_frames);
				seg_end = longint'(n) * SEG_MS;
				t = play_time;
				go = 1;
				if (t >= seg_end) begin
					if (looping) t = t % seg_end;
					else go = 0;
				end
				if (go) begin
					k = int'(t / SEG_MS);
					l1 = (t % SEG_MS) / 1000;
					l2 = (l1 * l1) >> 16;
					l3 = (l2 * l1) >> 16;
					kp = k == 0 ? n - 1 : k - 1;
					kn = k + 1 < n ? k + 1 : 0;
					knn = kn + 1 < n ? kn + 1 : 0;
					hold_x = 32'(bezier_axis(key_tab_x[k], key_tab_x[kn], key_tab_x[kp],
						key_tab_x[knn], l1, l2, l3, dx));
					hold_y = 32'(bezier_axis(key_tab_y[k], key_tab_y[kn], key_tab_y[kp],
						key_tab_y[knn], l1, l2, l3, dy));
					hold_z = 32'(bezier_axis(key_tab_z[k], key_tab_z[kn], key_tab_z[kp],
						key_tab_z[knn], l1, l2, l3, dz));
					r.mv = 1;
					sq = longint'(dx * dx) + longint'(dy * dy) + longint'(dz * dz);
					len = int_sqrt(sq);
					if (len == 0) begin
						r.flt = 1;
						play_time = t[31:0];
					end else begin
						stp = (longint'(speed) * longint'(it.tv)) / len;
						nt = stp > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : t + stp;
						if (nt > 64'hFFFF_FFFF) nt = 64'hFFFF_FFFF;
						play_time = nt[31:0];
					end
				end
			end
			default: ;
		endcase
		r.x = hold_x;
		r.y = hold_y;
		r.z = hold_z;
		r.t = play_time;
		return r;
	endfunction

	// result checker
	always @(posedge clk) begin
		if (result_valid) begin
			if (pos_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
			end else begin
				path_pos_t e;
				e = pos_q.pop_front();
				if (out_x !== e.x || out_y !== e.y || out_z !== e.z || out_time !== e.t ||
						moved !== e.mv || speed_fault !== e.flt) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch %0t exp %h %h %h %h %b %b got %h %h %h %h %b %b",
							$realtime, e.x, e.y, e.z, e.t, e.mv, e.flt,
							out_x, out_y, out_z, out_time, moved, speed_fault);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((start && !busy) || result_valid) begin
			stall_cnt <= 0;
		end else begin
			stall_cnt <= stall_cnt + 1;
			if (stall_cnt >= STALL_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	task automatic send_item(path_item_t it);
		start <= 1;
		command <= it.cmd;
		frame_index <= it.idx;
		key_x <= it.kx;
		key_y <= it.ky;
		key_z <= it.kz;
		time_value <= it.tv;
		do @(posedge clk); while (busy);
		pos_q = {pos_q, advance_path(it)};
		if ($urandom_range(99) < idle_pct) begin
			start <= 0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic send_cmd(logic [2:0] c, logic [31:0] tv);
		path_item_t it;
		it = '{c, 6'($urandom), $urandom, $urandom, $urandom, tv};
		send_item(it);
	endtask

	task automatic set_reg(logic [1:0] ri, logic [31:0] val);
		start <= 0;
		while (pos_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		psel <= 1;
		pwrite <= 1;
		paddr <= {ri, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		case (ri)
			REG_FRAME_COUNT: n_frames = val[6:0];
			REG_LOOP_ENABLE: looping = val[0];
			default: speed = val;
		endcase
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(3))
			0: return $urandom;
			1: return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
			default: return 32'($signed($urandom_range(200000)) - 100000) <<< 8;
		endcase
	endfunction

	task automatic test_fill_table();
		for (int i = 0; i < MAX_FRAMES; i++)
			send_item('{CMD_WRITE, 6'(i), rand_coord(), rand_coord(), rand_coord(), $urandom});
	endtask

	task automatic test_directed();
		send_cmd(CMD_TICK, 32'h0001_0000);
		set_reg(REG_FRAME_COUNT, 32'd1);
		send_cmd(CMD_TICK, 32'h0001_0000);
		send_item('{CMD_WRITE, 6'd0, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h0});
		send_item('{CMD_WRITE, 6'd1, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h0});
		send_item('{CMD_WRITE, 6'd63, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h0});
		set_reg(REG_FRAME_COUNT, 32'd2);
		send_cmd(CMD_TICK, 32'hffff_ffff);
		send_cmd(CMD_TICK, 32'h0000_0000);
		send_cmd(CMD_JUMP, 32'hffff_ffff);
		send_cmd(CMD_TICK, 32'h0001_0000);
		set_reg(REG_LOOP_ENABLE, 32'd1);
		set_reg(REG_TARGET_SPEED, 32'hffff_ffff);
		send_cmd(CMD_TICK, 32'hffff_ffff);
		send_cmd(CMD_PAUSE, 32'h0);
		send_cmd(CMD_TICK, 32'h0001_0000);
		send_cmd(CMD_START, 32'h0);
		send_cmd(CMD_JUMP, 32'(SEG_MS * 2 - 1));
		send_cmd(CMD_TICK, 32'h0001_0000);
		for (int c = CMD_ODD_LO; c <= CMD_ODD_HI; c++) send_cmd(3'(c), $urandom);
		set_reg(REG_TARGET_SPEED, 32'h0);
		send_cmd(CMD_TICK, 32'h0100_0000);
		set_reg(REG_FRAME_COUNT, 32'd64);
		send_cmd(CMD_JUMP, 32'(SEG_MS * 63 + 5));
		send_cmd(CMD_TICK, 32'h0100_0000);
		set_reg(REG_FRAME_COUNT, 32'd100);
		send_cmd(CMD_TICK, 32'h0001_0000);
	endtask

	task automatic test_random(int pct, int count);
		int r, fc;
		idle_pct = pct;
		for (int i = 0; i < count; i++) begin
			if (i % 60 == 0) begin
				r = $urandom_range(9);
				fc = r < 6 ? $urandom_range(2, 8) : r == 6 ? 1 : r == 7 ? 64 :
					r == 8 ? 0 : $urandom_range(65, 127);
				set_reg(REG_FRAME_COUNT, 32'(fc));
				set_reg(REG_LOOP_ENABLE, 32'($urandom_range(1)));
				r = $urandom_range(3);
				set_reg(REG_TARGET_SPEED, r == 0 ? $urandom :
					32'($urandom_range(1, 200)) << 16);
			end
			r = $urandom_range(99);
			if (r < 55)
				send_cmd(CMD_TICK, $urandom_range(3) == 0 ? $urandom :
					32'($urandom_range(1, 1 << 20)) << 4);
			else if (r < 70)
				send_item('{CMD_WRITE, 6'($urandom), rand_coord(), rand_coord(), rand_coord(),
					$urandom});
			else if (r < 82)
				send_cmd(CMD_JUMP, $urandom_range(3) == 0 ? $urandom :
					32'($urandom_range(0, (n_frames == 0 ? 1 : n_frames) * 65535) * 1000));
			else if (r < 88)
				send_cmd(CMD_PAUSE, $urandom);
			else if (r < 96)
				send_cmd(CMD_START, $urandom);
			else
				send_cmd(3'($urandom_range(CMD_ODD_LO, CMD_ODD_HI)), $urandom);
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed_prefill: begin
			send_cmd(CMD_TICK, 32'h0001_0000);
		end
		test_fill_table();
		test_directed();
		test_random(11, 240);
		test_random(53, 240);
		test_random(0, 240);
		start <= 0;
		while (pos_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
